// ===== sv/cdavf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdavf_pkg
// Shared widths, constants and helpers for the CD audio volume fader.
// ============================================================================
package cdavf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int VOL_W    = 12;
   localparam int MUL_W    = 11;
   localparam int PROD_W   = SAMPLE_W + MUL_W + 1;
   localparam int DIV_SH   = 10;
   localparam int ADDR_W   = 3;

   // Full volume, also the reset value of both volumes.
   localparam logic [VOL_W-1:0] VOL_FULL   = 12'h400;
   localparam logic [VOL_W-1:0] MUL_COARSE = 12'h7FC;
   localparam logic [VOL_W-1:0] MUL_FINE   = 12'h003;

   // Register word index (byte address divided by four).
   localparam logic REG_TARGET_VOLUME = 1'b0;

   // Truncating divide bias for negative products.
   localparam logic [PROD_W-1:0] DIV_BIAS = PROD_W'((1 << DIV_SH) - 1);

   // Multiplier taken from the current volume: coarse steps, or the fine
   // steps when the coarse bits are all zero. Bit 11 never takes part.
   function automatic logic [MUL_W-1:0] mul_from_volume(input logic [VOL_W-1:0] vol);
      logic [VOL_W-1:0] coarse;
      coarse = vol & MUL_COARSE;
      if (coarse == '0) begin
         mul_from_volume = MUL_W'(vol & MUL_FINE);
      end else begin
         mul_from_volume = coarse[MUL_W-1:0];
      end
   endfunction

   // One channel: sample times multiplier over 1024, truncated toward zero,
   // wrapped to the sample width.
   function automatic logic [SAMPLE_W-1:0] scale_sample(input logic signed [SAMPLE_W-1:0] s,
                                                        input logic [MUL_W-1:0] mul);
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] biased;
      prod   = PROD_W'(s) * $signed({1'b0, mul});
      biased = prod[PROD_W-1] ? (prod + $signed(DIV_BIAS)) : prod;
      scale_sample = biased[DIV_SH +: SAMPLE_W];
   endfunction

endpackage

// ===== sv/cd_audio_volume_fader.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cd_audio_volume_fader
// Stereo CD audio attenuator whose volume ramps one step per played request.
// ============================================================================
// Requests pass the multiplier stage, then the output register (rsp_tvalid).
// Throughput: one request per cycle while rsp_tready is high; the multiplier
// stage and the output register each hold one request and advance together.
// Reset (synchronous, active high) empties both stages and sets the current
// and target volume to full volume (0x400).
module cd_audio_volume_fader (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] left_in, [31:16] right_in
   input  logic        req_tuser,   // [0] audio_playing
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] left_out, [31:16] right_out
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SW = cdavf_pkg::SAMPLE_W;
   localparam int VW = cdavf_pkg::VOL_W;
   localparam int MW = cdavf_pkg::MUL_W;

   logic [VW-1:0] target_ff, target_in;
   logic [VW-1:0] volume_ff, volume_in;

   logic          s1_valid_ff, s1_valid_in;
   logic [SW-1:0] s1_left_ff, s1_right_ff;
   logic [MW-1:0] s1_mul_ff, s1_mul_in;

   logic          out_valid_ff, out_valid_in;
   logic [SW-1:0] out_left_ff, out_right_ff;

   logic req_acc, s1_move, out_free, csr_wr;

   // Handshake: each stage moves when the one after it has room.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_acc    = req_tvalid && req_tready;

   // Configuration register write and read.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == cdavf_pkg::REG_TARGET_VOLUME) ?
                       {{(32-VW){1'b0}}, target_ff} : 32'd0;

   always_comb begin
      target_in = target_ff;
      if (csr_wr && (csr_paddr[2] == cdavf_pkg::REG_TARGET_VOLUME)) begin
         target_in = csr_pwdata[VW-1:0];
      end
   end

   // Multiplier choice and volume step for the request being accepted.
   always_comb begin
      volume_in = volume_ff;
      s1_mul_in = '0;
      if (req_acc && req_tuser) begin
         s1_mul_in = cdavf_pkg::mul_from_volume(volume_ff);
         if (volume_ff < target_ff) begin
            volume_in = volume_ff + VW'(1);
         end else if (volume_ff > target_ff) begin
            volume_in = volume_ff - VW'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= cdavf_pkg::VOL_FULL;
         volume_ff    <= cdavf_pkg::VOL_FULL;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         volume_ff    <= volume_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: input register, then the scaled samples into the result register.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_left_ff  <= req_tdata[SW-1:0];
         s1_right_ff <= req_tdata[2*SW-1:SW];
         s1_mul_ff   <= s1_mul_in;
      end
      if (s1_move) begin
         out_left_ff  <= cdavf_pkg::scale_sample($signed(s1_left_ff), s1_mul_ff);
         out_right_ff <= cdavf_pkg::scale_sample($signed(s1_right_ff), s1_mul_ff);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_right_ff, out_left_ff};

`ifndef NO_ASSERTIONS
   // The current volume moves by at most one step per cycle.
   a_volume_step: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> (volume_ff == $past(volume_ff)) ||
                      (volume_ff == $past(volume_ff) + VW'(1)) ||
                      (volume_ff == $past(volume_ff) - VW'(1)))
      else $error("current volume jumped by more than one step");

   // The volume holds unless a playing request is accepted.
   a_volume_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_acc && req_tuser) |=> $stable(volume_ff))
      else $error("current volume changed without a playing request");

   // A request that is not playing carries a zero multiplier.
   a_silent_mul: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !req_tuser) |=> (s1_mul_ff == '0))
      else $error("silent request carries a nonzero multiplier");

   // A stalled result is not overwritten by the multiplier stage.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !s1_move)
      else $error("stage moved into a stalled result register");
`endif

endmodule

// ===== verif/cd_audio_fader_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cd_audio_fader_checker
// Watches the request, result and register ports of the CD audio volume
// fader. It keeps its own copy of the target and current volume, predicts the
// faded sample pair of every accepted request and compares each returned
// result, field by field, with the oldest prediction still waiting.
// ============================================================================
module cd_audio_fader_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] left_in, [31:16] right_in
   input  logic        req_tuser,   // [0] audio_playing
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [15:0] left_out, [31:16] right_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          mismatches,
   output int          pending
);

   localparam logic [cdavf_pkg::ADDR_W-1:0] TARGET_VOLUME_ADDR =
      cdavf_pkg::ADDR_W'(cdavf_pkg::REG_TARGET_VOLUME) << 2;
   localparam int FULL_SCALE = 1 << cdavf_pkg::DIV_SH;

   typedef struct packed {
      logic [cdavf_pkg::SAMPLE_W-1:0] right_pcm;
      logic [cdavf_pkg::SAMPLE_W-1:0] left_pcm;
   } sample_pair_type;

   sample_pair_type                 faded_pairs[$];
   logic [cdavf_pkg::VOL_W-1:0]     target_vol = cdavf_pkg::VOL_FULL;
   logic [cdavf_pkg::VOL_W-1:0]     fader_vol  = cdavf_pkg::VOL_FULL;

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   // The gain uses volume bits 10..2, or bits 1..0 alone when the upper
   // ones are all clear. Bit 11 never reaches the gain.
   function automatic logic [cdavf_pkg::MUL_W-1:0] fader_gain(
      input logic [cdavf_pkg::VOL_W-1:0] vol);
      logic [cdavf_pkg::MUL_W-1:0] coarse;
      coarse = {vol[10:2], 2'b00};
      return (coarse != '0) ? coarse : cdavf_pkg::MUL_W'(vol[1:0]);
   endfunction

   // One channel: the integer divide truncates toward zero, and the
   // quotient wraps to the sample width without saturation.
   function automatic logic [cdavf_pkg::SAMPLE_W-1:0] attenuate(
      input logic signed [cdavf_pkg::SAMPLE_W-1:0] pcm,
      input logic [cdavf_pkg::MUL_W-1:0] gain);
      int product;
      int quotient;
      product  = int'(pcm) * int'(gain);
      quotient = product / FULL_SCALE;
      return quotient[cdavf_pkg::SAMPLE_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : monitor
      sample_pair_type             want;
      logic [cdavf_pkg::MUL_W-1:0] gain;
      if (reset) begin
         faded_pairs.delete();
         target_vol = cdavf_pkg::VOL_FULL;
         fader_vol  = cdavf_pkg::VOL_FULL;
      end else begin
         // Results first: they belong to requests accepted at earlier edges.
         if (rsp_tvalid && rsp_tready) begin
            if (faded_pairs.size() == 0) begin
               report_mismatch("result with no request outstanding", rsp_tdata, '0);
            end else begin
               want = faded_pairs.pop_front();
               if (rsp_tdata[15:0] !== want.left_pcm) begin
                  report_mismatch("left_out", rsp_tdata[15:0], want.left_pcm);
               end
               if (rsp_tdata[31:16] !== want.right_pcm) begin
                  report_mismatch("right_out", rsp_tdata[31:16], want.right_pcm);
               end
            end
         end

         // A played request is scaled at the old volume, then the volume
         // takes one step toward the target. Silence holds the volume.
         if (req_tvalid && req_tready) begin
            want = '0;
            if (req_tuser) begin
               gain           = fader_gain(fader_vol);
               want.left_pcm  = attenuate(req_tdata[15:0], gain);
               want.right_pcm = attenuate(req_tdata[31:16], gain);
               if (fader_vol < target_vol) begin
                  fader_vol++;
               end else if (fader_vol > target_vol) begin
                  fader_vol--;
               end
            end
            faded_pairs.push_back(want);
         end

         // Register access phase: track writes and check reads.
         if (csr_psel && csr_penable && csr_pready && csr_paddr == TARGET_VOLUME_ADDR) begin
            if (csr_pwrite) begin
               target_vol = csr_pwdata[cdavf_pkg::VOL_W-1:0];
            end else if (csr_prdata !== 32'(target_vol)) begin
               report_mismatch("target_volume read", csr_prdata, 32'(target_vol));
            end
         end
      end
      pending = faded_pairs.size();
   end

endmodule

// ===== verif/tb_cd_audio_volume_fader.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_cd_audio_volume_fader
// Drives stereo sample requests and target volume writes into the fader and
// gives the verdict. A few directed requests cover the sample extremes,
// silence and wrapping products; random phases then ramp the volume up past
// bit 11, where the fine and zero gains show up again, hold there, and come
// back to the largest gain, with random idle cycles on both channels, a
// stretch with none and a long result stall. The checker does the scoring.
// ============================================================================
module tb_cd_audio_volume_fader;

   localparam logic [cdavf_pkg::ADDR_W-1:0] TARGET_VOLUME_ADDR =
      cdavf_pkg::ADDR_W'(cdavf_pkg::REG_TARGET_VOLUME) << 2;
   localparam int IDLE_PCT        = 18;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 6;
   localparam int RUN_LIMIT_NS    = 1_000_000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;    // [15:0] left_in, [31:16] right_in
   logic        req_tuser   = 1'b0;  // [0] audio_playing
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;           // [15:0] left_out, [31:16] right_out
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatches;
   int pending;
   int req_idle_pct   = IDLE_PCT;
   int rsp_idle_pct   = IDLE_PCT;
   int hold_off_asked = 0;

   cd_audio_volume_fader dut (.*);

   cd_audio_fader_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard limit on the run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off whenever one is asked.
   initial begin : rsp_ready_gen
      int hold_off_done;
      hold_off_done = 0;
      forever begin
         @(negedge clock);
         if (hold_off_done < hold_off_asked) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_done++;
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Mostly random samples, with the extremes mixed in often.
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the request
   // is taken, leaving tvalid high so the next request can follow directly.
   task automatic send_request(input logic [15:0] left_pcm, input logic [15:0] right_pcm,
                               input logic playing);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right_pcm, left_pcm};
      req_tuser  <= playing;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [cdavf_pkg::ADDR_W-1:0] addr,
                             input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // New fader target, written while the block is idle and read back.
   // The bits above the register width carry noise.
   task automatic set_target(input logic [cdavf_pkg::VOL_W-1:0] vol);
      wait_idle();
      csr_access(1'b1, TARGET_VOLUME_ADDR, {20'($urandom), vol});
      csr_access(1'b0, TARGET_VOLUME_ADDR, '0);
   endtask

   // Random requests until the given number of played ones went out.
   task automatic run_fade(input int played_goal, input int play_pct);
      int   played;
      logic playing;
      played = 0;
      while (played < played_goal) begin
         playing = ($urandom_range(99) < play_pct);
         send_request(pick_sample(), pick_sample(), playing);
         if (playing) begin
            played++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Full volume after reset: samples pass through unchanged.
      send_request(16'h8000, 16'h7FFF, 1'b1);
      send_request(16'h7FFF, 16'h8000, 1'b1);
      send_request(16'h0000, 16'hFFFF, 1'b1);
      send_request(16'h0001, 16'hFFFE, 1'b1);
      send_request(16'hAAAA, 16'h5555, 1'b1);
      // Silence gives zero outputs whatever the samples are.
      send_request(16'h7FFF, 16'h8000, 1'b0);
      send_request(16'hFFFF, 16'hFFFF, 1'b0);

      // Ramp slightly above full volume so that the extremes wrap around;
      // silent requests in between must hold the ramp.
      set_target(12'd1028);
      send_request(16'h7FFF, 16'h8000, 1'b1);
      send_request(16'h7FFF, 16'h8000, 1'b0);
      send_request(16'hFFFF, 16'h0001, 1'b1);
      send_request(16'h8001, 16'h7FFE, 1'b1);
      send_request(16'h7FFF, 16'h8000, 1'b1);
      send_request(16'h7FFF, 16'h8000, 1'b1);
      send_request(16'h8000, 16'h7FFF, 1'b1);
      send_request(16'hFFFF, 16'hFC00, 1'b1);

      // Fade up past bit 11, first without any idle cycles. Just above
      // 0x800 the coarse bits clear, so zero and fine gains appear.
      set_target(12'hFFF);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_fade(300, 95);
      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;
      hold_off_asked++;
      run_fade(730, 95);

      // Step back down and hold at a fine gain of one.
      set_target(12'h801);
      run_fade(60, 90);

      // Through zero gain down to the largest gain and hold there.
      set_target(12'h7FF);
      run_fade(40, 90);

      // Somewhere around bit 11.
      set_target(cdavf_pkg::VOL_W'($urandom_range(2200, 1900)));
      run_fade(150, 85);

      wait_idle();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
